>>> hdl/layer_zorder_stack_assert.svh
// Assertion macros used by the layer z-order stack datapath.
`ifndef LAYER_ZORDER_STACK_ASSERT_SVH
`define LAYER_ZORDER_STACK_ASSERT_SVH

// The condition must never be true outside reset.
`define LZS_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("layer stack check failed: forbidden condition");

// When the antecedent holds, the consequent holds in the same cycle.
`define LZS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("layer stack check failed: implication");

// When the antecedent holds, the consequent holds in the next cycle.
`define LZS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("layer stack check failed: next-cycle implication");

`endif

>>> hdl/lzs_pkg.sv
// Package with the constants, codes and interface types of the layer z-order stack.
`default_nettype none

package lzs_pkg;

    // Number of layer slots and the widths that follow from it.
    localparam int LAYERS = 256;
    localparam int IDX_W  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int CNT_W  = IDX_W + 1;

    // Fixed field widths.
    localparam int FUNC_W = 2;
    localparam int SLOT_W = 8;
    localparam int HGT_W  = 9;
    localparam int REQ_W  = 10;
    localparam int CALC_W = 11;

    localparam logic [SLOT_W:0] LAYER_LIMIT = LAYERS[SLOT_W:0];
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(LAYERS - 1);

    localparam logic signed [HGT_W-1:0]  HGT_NONE  = '1;
    localparam logic signed [HGT_W-1:0]  HGT_ZERO  = '0;
    localparam logic signed [HGT_W-1:0]  HGT_ONE   = HGT_W'(1);
    localparam logic signed [CALC_W-1:0] CALC_NEG1 = '1;
    localparam logic signed [CALC_W-1:0] CALC_ZERO = '0;
    localparam logic signed [CALC_W-1:0] CALC_ONE  = CALC_W'(1);

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_MOVE  = 2'd1,
        FUNC_FREE  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PLAN,
        ST_SHIFT,
        ST_PLACE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic plan;
        logic shift_en;
        logic place;
        logic scan_en;
        logic load_out;
    } lzs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        func_t func;
        logic  live;
        logic  shift_done;
        logic  scan_end;
        logic  out_free;
    } lzs_status_t;

endpackage

`default_nettype wire

>>> hdl/lzs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lzs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/lzs_ctrl.sv
// Controller state machine that sequences allocate, move and free operations.
`default_nettype none

module lzs_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire lzs_pkg::lzs_status_t status,
    output      lzs_pkg::lzs_cmd_t    cmd
);

    import lzs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // The height read of the addressed slot is in flight here.
                if (status.func == FUNC_ALLOC) begin
                    state_next = ST_SCAN;
                end else if ((status.func == FUNC_MOVE || status.func == FUNC_FREE)
                             && status.live) begin
                    state_next = ST_PLAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PLAN: begin
                cmd.plan   = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.shift_en = 1'b1;
                if (status.shift_done) begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                cmd.place  = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (status.scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/lzs_datapath.sv
// Datapath with the order and height tables, slot use bits, shift engine and output register.
`default_nettype none
`include "layer_zorder_stack_assert.svh"

module lzs_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire lzs_pkg::lzs_cmd_t                 cmd,
    output      lzs_pkg::lzs_status_t              status,
    input  wire logic [lzs_pkg::FUNC_W-1:0]        s_func,
    input  wire logic [lzs_pkg::SLOT_W-1:0]        s_layer_id,
    input  wire logic signed [lzs_pkg::REQ_W-1:0]  s_target_height,
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic                              m_ok,
    output      logic [lzs_pkg::SLOT_W-1:0]        m_slot_out,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_old_height,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_new_height,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_top_out,
    output      logic                              m_redraw,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_map_from,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_draw_low,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_draw_high
);

    import lzs_pkg::*;

    // Control state.
    logic                     m_valid_reg;
    logic                     pend_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [HGT_W-1:0]  top_reg;
    logic [LAYERS-1:0]        in_use_reg;

    // Transaction and working registers.
    func_t                    func_reg;
    logic [SLOT_W-1:0]        id_reg;
    logic signed [REQ_W-1:0]  req_reg;
    logic [IDX_W-1:0]         src_reg;
    logic [IDX_W-1:0]         pend_src_reg;
    logic [IDX_W-1:0]         scan_reg;
    logic                     dir_up_reg;
    logic                     top_inc_reg;
    logic                     top_dec_reg;

    // Result of the current transaction.
    logic                     res_ok_reg;
    logic [SLOT_W-1:0]        res_slot_reg;
    logic signed [HGT_W-1:0]  res_old_reg;
    logic signed [HGT_W-1:0]  res_new_reg;
    logic                     res_redraw_reg;
    logic signed [HGT_W-1:0]  res_mf_reg;
    logic signed [HGT_W-1:0]  res_dl_reg;
    logic signed [HGT_W-1:0]  res_dh_reg;

    // Output register.
    logic                     m_ok_reg;
    logic [SLOT_W-1:0]        m_slot_reg;
    logic signed [HGT_W-1:0]  m_old_reg;
    logic signed [HGT_W-1:0]  m_new_reg;
    logic signed [HGT_W-1:0]  m_top_reg;
    logic                     m_redraw_reg;
    logic signed [HGT_W-1:0]  m_mf_reg;
    logic signed [HGT_W-1:0]  m_dl_reg;
    logic signed [HGT_W-1:0]  m_dh_reg;

    // Table ports.
    logic                     ot_we;
    logic [IDX_W-1:0]         ot_waddr;
    logic [SLOT_W-1:0]        ot_wdata;
    logic                     ot_re;
    logic [SLOT_W-1:0]        ot_rdata;
    logic                     lh_we;
    logic [IDX_W-1:0]         lh_waddr;
    logic signed [HGT_W-1:0]  lh_wdata;
    logic [HGT_W-1:0]         lh_rdata;

    logic [IDX_W-1:0]         id_idx;
    logic                     issue;
    logic [IDX_W-1:0]         dst;
    logic                     scan_hit;
    logic                     scan_last;
    logic                     out_free;

    // Planning arithmetic.
    logic signed [HGT_W-1:0]  old_h;
    logic signed [CALC_W-1:0] old_c;
    logic signed [CALC_W-1:0] top_c;
    logic signed [CALC_W-1:0] req_c;
    logic signed [CALC_W-1:0] top_p1;
    logic signed [CALC_W-1:0] h_a;
    logic signed [CALC_W-1:0] h_b;
    logic signed [CALC_W-1:0] h_c;
    logic signed [CALC_W-1:0] src_c;
    logic signed [CALC_W-1:0] cnt_c;
    logic signed [CALC_W-1:0] mf_c;
    logic signed [CALC_W-1:0] dl_c;
    logic signed [CALC_W-1:0] dh_c;
    logic                     lower;
    logic                     hide;
    logic                     raise;
    logic                     show;

    lzs_ram #(.WIDTH(SLOT_W), .DEPTH(LAYERS)) u_order_ram (
        .clk   (aclk),
        .we    (ot_we),
        .waddr (ot_waddr),
        .wdata (ot_wdata),
        .re    (ot_re),
        .raddr (src_reg),
        .rdata (ot_rdata)
    );

    // The height table is read continuously at the addressed slot.
    lzs_ram #(.WIDTH(HGT_W), .DEPTH(LAYERS)) u_height_ram (
        .clk   (aclk),
        .we    (lh_we),
        .waddr (lh_waddr),
        .wdata (lh_wdata),
        .re    (1'b1),
        .raddr (id_idx),
        .rdata (lh_rdata)
    );

    assign id_idx    = id_reg[IDX_W-1:0];
    assign issue     = cmd.shift_en && (cnt_reg != '0);
    assign dst       = dir_up_reg ? (pend_src_reg + IDX_W'(1)) : (pend_src_reg - IDX_W'(1));
    assign scan_hit  = !in_use_reg[scan_reg];
    assign scan_last = (scan_reg == LAST_IDX);
    assign out_free  = !m_valid_reg || m_ready;

    // Status toward the controller.
    always_comb begin
        status.func       = func_reg;
        status.live       = ({1'b0, id_reg} < LAYER_LIMIT) && in_use_reg[id_idx];
        status.shift_done = (cnt_reg == '0) && !pend_reg;
        status.scan_end   = scan_hit || scan_last;
        status.out_free   = out_free;
    end

    // Clamp the requested height and work out the shift and the repaint ranges.
    always_comb begin
        old_h  = lh_rdata;
        old_c  = CALC_W'(old_h);
        top_c  = CALC_W'(top_reg);
        req_c  = CALC_W'(req_reg);
        top_p1 = top_c + CALC_ONE;
        h_a    = (req_c > top_p1) ? top_p1 : req_c;
        h_b    = (!old_c[CALC_W-1] && (h_a > top_c)) ? top_c : h_a;
        h_c    = (h_b < CALC_NEG1) ? CALC_NEG1 : h_b;
        if (func_reg == FUNC_FREE) begin
            h_c = CALC_NEG1;
        end
        lower = (old_c > h_c) && !h_c[CALC_W-1];
        hide  = (old_c > h_c) && h_c[CALC_W-1];
        raise = (old_c < h_c) && !old_c[CALC_W-1];
        show  = (old_c < h_c) && old_c[CALC_W-1];
        src_c = CALC_ZERO;
        cnt_c = CALC_ZERO;
        mf_c  = CALC_ZERO;
        dl_c  = CALC_ZERO;
        dh_c  = CALC_NEG1;
        if (lower) begin
            src_c = old_c - CALC_ONE;
            cnt_c = old_c - h_c;
            mf_c  = h_c + CALC_ONE;
            dl_c  = h_c + CALC_ONE;
            dh_c  = old_c;
        end else if (hide) begin
            src_c = old_c + CALC_ONE;
            cnt_c = top_c - old_c;
            dh_c  = old_c - CALC_ONE;
        end else if (raise) begin
            src_c = old_c + CALC_ONE;
            cnt_c = h_c - old_c;
            mf_c  = h_c;
            dl_c  = h_c;
            dh_c  = h_c;
        end else if (show) begin
            src_c = top_c;
            cnt_c = top_c - h_c + CALC_ONE;
            mf_c  = h_c;
            dl_c  = h_c;
            dh_c  = h_c;
        end
    end

    // Table write ports: shift moves, final placement and slot grant.
    always_comb begin
        ot_re    = issue;
        ot_we    = 1'b0;
        ot_waddr = dst;
        ot_wdata = ot_rdata;
        lh_we    = 1'b0;
        lh_waddr = ot_rdata[IDX_W-1:0];
        lh_wdata = HGT_W'(dst);
        if (pend_reg) begin
            ot_we = 1'b1;
            lh_we = 1'b1;
        end else if (cmd.place) begin
            lh_we    = res_redraw_reg;
            lh_waddr = id_idx;
            lh_wdata = res_new_reg;
            ot_we    = res_redraw_reg && !res_new_reg[HGT_W-1];
            ot_waddr = res_new_reg[IDX_W-1:0];
            ot_wdata = id_reg;
        end else if (cmd.scan_en && scan_hit) begin
            lh_we    = 1'b1;
            lh_waddr = scan_reg;
            lh_wdata = HGT_NONE;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
            top_reg     <= HGT_NONE;
            in_use_reg  <= '0;
        end else begin
            pend_reg <= issue;
            if (cmd.plan) begin
                cnt_reg <= cnt_c[CNT_W-1:0];
            end else if (issue) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.place) begin
                if (top_inc_reg) begin
                    top_reg <= top_reg + HGT_ONE;
                end else if (top_dec_reg) begin
                    top_reg <= top_reg - HGT_ONE;
                end
                if (func_reg == FUNC_FREE) begin
                    in_use_reg[id_idx] <= 1'b0;
                end
            end
            if (cmd.scan_en && scan_hit) begin
                in_use_reg[scan_reg] <= 1'b1;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction, working and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            func_reg       <= func_t'(s_func);
            id_reg         <= s_layer_id;
            req_reg        <= s_target_height;
            scan_reg       <= '0;
            res_ok_reg     <= 1'b1;
            res_slot_reg   <= s_layer_id;
            res_old_reg    <= HGT_NONE;
            res_new_reg    <= HGT_NONE;
            res_redraw_reg <= 1'b0;
            res_mf_reg     <= HGT_ZERO;
            res_dl_reg     <= HGT_ZERO;
            res_dh_reg     <= HGT_NONE;
        end
        if (cmd.plan) begin
            src_reg        <= src_c[IDX_W-1:0];
            dir_up_reg     <= lower || show;
            top_inc_reg    <= show;
            top_dec_reg    <= hide;
            res_old_reg    <= old_h;
            res_new_reg    <= HGT_W'(h_c);
            res_redraw_reg <= lower || hide || raise || show;
            res_mf_reg     <= HGT_W'(mf_c);
            res_dl_reg     <= HGT_W'(dl_c);
            res_dh_reg     <= HGT_W'(dh_c);
        end else if (issue) begin
            src_reg <= dir_up_reg ? (src_reg - IDX_W'(1)) : (src_reg + IDX_W'(1));
        end
        if (issue) begin
            pend_src_reg <= src_reg;
        end
        if (cmd.scan_en) begin
            if (scan_hit) begin
                res_ok_reg   <= 1'b1;
                res_slot_reg <= SLOT_W'(scan_reg);
            end else if (scan_last) begin
                res_ok_reg   <= 1'b0;
                res_slot_reg <= '0;
            end else begin
                scan_reg <= scan_reg + IDX_W'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_ok_reg     <= res_ok_reg;
            m_slot_reg   <= res_slot_reg;
            m_old_reg    <= res_old_reg;
            m_new_reg    <= res_new_reg;
            m_top_reg    <= top_reg;
            m_redraw_reg <= res_redraw_reg;
            m_mf_reg     <= res_mf_reg;
            m_dl_reg     <= res_dl_reg;
            m_dh_reg     <= res_dh_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_slot_out   = m_slot_reg;
    assign m_old_height = m_old_reg;
    assign m_new_height = m_new_reg;
    assign m_top_out    = m_top_reg;
    assign m_redraw     = m_redraw_reg;
    assign m_map_from   = m_mf_reg;
    assign m_draw_low   = m_dl_reg;
    assign m_draw_high  = m_dh_reg;

    // A pending shift write must never collide with the final placement.
    `LZS_ASSERT_NEVER(a_shift_place_overlap, aclk, aresetn, pend_reg && cmd.place)
    // A result is loaded only when the output register can take it.
    `LZS_ASSERT_IMPL(a_load_when_free, aclk, aresetn, cmd.load_out, !m_valid_reg || m_ready)
    // A granted slot is marked used in the following cycle.
    `LZS_ASSERT_NEXT(a_grant_marks_used, aclk, aresetn, cmd.scan_en && scan_hit, in_use_reg[$past(scan_reg)])

endmodule

`default_nettype wire

>>> hdl/layer_zorder_stack.sv
// Layer z-order stack top level: controller and datapath with valid/ready channels.
// The block handles one transaction at a time and accepts a new one while the previous
// result waits in the output register. Allocate scans the slot use bits one per cycle.
// Move and free read the layer height, then shift the layers in between through the
// order table one entry per cycle, pipelined over its registered read port. A full
// output register holds back the result of any transaction. The order and height
// tables come up undefined and need no clearing; the stack is empty and all slots
// are free after reset.
`default_nettype none

module layer_zorder_stack (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire logic [lzs_pkg::FUNC_W-1:0]        s_func,
    input  wire logic [lzs_pkg::SLOT_W-1:0]        s_layer_id,
    input  wire logic signed [lzs_pkg::REQ_W-1:0]  s_target_height,
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic                              m_ok,
    output      logic [lzs_pkg::SLOT_W-1:0]        m_slot_out,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_old_height,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_new_height,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_top_out,
    output      logic                              m_redraw,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_map_from,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_draw_low,
    output      logic signed [lzs_pkg::HGT_W-1:0]  m_draw_high
);

    import lzs_pkg::*;

    lzs_cmd_t    cmd;
    lzs_status_t status;

    // Sequencing of each transaction.
    lzs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Tables, arithmetic and output register.
    lzs_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_func          (s_func),
        .s_layer_id      (s_layer_id),
        .s_target_height (s_target_height),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_slot_out      (m_slot_out),
        .m_old_height    (m_old_height),
        .m_new_height    (m_new_height),
        .m_top_out       (m_top_out),
        .m_redraw        (m_redraw),
        .m_map_from      (m_map_from),
        .m_draw_low      (m_draw_low),
        .m_draw_high     (m_draw_high)
    );

endmodule

`default_nettype wire

>>> bench/layer_zorder_stack_checker.sv
// Checker for the layer z-order stack: predicts each result and compares it on the result channel.
module layer_zorder_stack_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire logic [lzs_pkg::FUNC_W-1:0]        s_func,
    input  wire logic [lzs_pkg::SLOT_W-1:0]        s_layer_id,
    input  wire logic signed [lzs_pkg::REQ_W-1:0]  s_target_height,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic                              m_ok,
    input  wire logic [lzs_pkg::SLOT_W-1:0]        m_slot_out,
    input  wire logic signed [lzs_pkg::HGT_W-1:0]  m_old_height,
    input  wire logic signed [lzs_pkg::HGT_W-1:0]  m_new_height,
    input  wire logic signed [lzs_pkg::HGT_W-1:0]  m_top_out,
    input  wire logic                              m_redraw,
    input  wire logic signed [lzs_pkg::HGT_W-1:0]  m_map_from,
    input  wire logic signed [lzs_pkg::HGT_W-1:0]  m_draw_low,
    input  wire logic signed [lzs_pkg::HGT_W-1:0]  m_draw_high,
    output int                                     failures,
    output int                                     pending,
    output int                                     results_checked,
    output int                                     repaints_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import lzs_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [HGT_W-1:0]  old_h;
        logic [HGT_W-1:0]  new_h;
        logic [HGT_W-1:0]  top;
        logic              redraw;
        logic [HGT_W-1:0]  map_from;
        logic [HGT_W-1:0]  draw_low;
        logic [HGT_W-1:0]  draw_high;
    } layer_result_t;

    // Predicted stack: slot at each height, height of each slot, slot use and top.
    logic [SLOT_W-1:0] order_at [0:255];
    int                height_of [0:LAYERS-1];
    bit                slot_used [0:LAYERS-1];
    int                top_h;

    layer_result_t expected_q[$];
    int            err_total;
    int            checked_total;
    int            redraw_total;

    initial begin
        err_total     = 0;
        checked_total = 0;
        redraw_total  = 0;
        top_h         = -1;
    end

    task automatic log_failure(input string msg);
        err_total++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic signed [9:0] got,
                                 input logic signed [9:0] want);
        if (got !== want) begin
            log_failure($sformatf("result %0d, %s: got %0d, expected %0d",
                                  checked_total, name, got, want));
        end
    endtask

    // Move slot id from its current height to height h, shifting the layers in between.
    task automatic restack_layer(input int id, input int h, output bit changed,
                                 output int mf, output int dl, output int dh);
        int old_h;
        int k;
        old_h   = height_of[id];
        changed = 1'b1;
        if (old_h > h) begin
            if (h >= 0) begin
                // Lowering a shown layer: the layers from h up to old_h - 1 move up by one.
                for (k = old_h; k > h; k--) begin
                    order_at[k] = order_at[k - 1];
                    height_of[order_at[k]] = k;
                end
                order_at[h] = 8'(id);
                mf = h + 1;
                dl = h + 1;
                dh = old_h;
            end else begin
                // Hiding: everything above drops by one and the stack shrinks.
                for (k = old_h; k < top_h; k++) begin
                    order_at[k] = order_at[k + 1];
                    height_of[order_at[k]] = k;
                end
                top_h--;
                mf = 0;
                dl = 0;
                dh = old_h - 1;
            end
        end else if (old_h < h) begin
            if (old_h >= 0) begin
                // Raising a shown layer: the layers in between move down by one.
                for (k = old_h; k < h; k++) begin
                    order_at[k] = order_at[k + 1];
                    height_of[order_at[k]] = k;
                end
            end else begin
                // Showing a hidden layer: open a gap at h and grow the stack.
                for (k = top_h; k >= h; k--) begin
                    order_at[k + 1] = order_at[k];
                    height_of[order_at[k + 1]] = k + 1;
                end
                top_h++;
            end
            order_at[h] = 8'(id);
            mf = h;
            dl = h;
            dh = h;
        end else begin
            changed = 1'b0;
        end
        if (changed) begin
            height_of[id] = h;
        end
    endtask

    // Work out the result of one accepted transaction and queue it.
    task automatic predict_layer_op(input func_t op, input logic [SLOT_W-1:0] id,
                                    input logic signed [REQ_W-1:0] req_raw);
        layer_result_t r;
        int            req;
        int            old_h;
        int            new_h;
        int            mf;
        int            dl;
        int            dh;
        bit            changed;
        bit            live;
        int            i;
        req     = int'(req_raw);
        r       = '0;
        r.ok    = 1'b1;
        r.slot  = id;
        old_h   = -1;
        new_h   = -1;
        changed = 1'b0;
        mf      = 0;
        dl      = 0;
        dh      = -1;
        live    = (int'(id) < LAYERS) && slot_used[id];
        case (op)
            FUNC_ALLOC: begin
                // Lowest free slot wins; it starts out hidden.
                r.ok   = 1'b0;
                r.slot = '0;
                for (i = 0; i < LAYERS && !r.ok; i++) begin
                    if (!slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        height_of[i] = -1;
                        r.ok         = 1'b1;
                        r.slot       = 8'(i);
                    end
                end
            end
            FUNC_MOVE: begin
                if (live) begin
                    old_h = height_of[id];
                    if (req > top_h + 1) req = top_h + 1;
                    if (old_h >= 0 && req > top_h) req = top_h;
                    if (req < -1) req = -1;
                    restack_layer(int'(id), req, changed, mf, dl, dh);
                    new_h = height_of[id];
                end
            end
            FUNC_FREE: begin
                if (live) begin
                    old_h = height_of[id];
                    if (old_h >= 0) begin
                        restack_layer(int'(id), -1, changed, mf, dl, dh);
                    end
                    slot_used[id] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (!changed) begin
            mf = 0;
            dl = 0;
            dh = -1;
        end
        r.old_h     = 9'(old_h);
        r.new_h     = 9'(new_h);
        r.top       = 9'(top_h);
        r.redraw    = changed;
        r.map_from  = 9'(mf);
        r.draw_low  = 9'(dl);
        r.draw_high = 9'(dh);
        expected_q.push_back(r);
    endtask

    // Compare each result transaction first, then predict the input transaction of this edge.
    always @(posedge aclk) begin
        layer_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < LAYERS; i++) slot_used[i] = 1'b0;
            top_h = -1;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    log_failure("result transaction with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    compare_field("ok", 10'(m_ok), 10'(want.ok));
                    compare_field("slot_out", 10'(m_slot_out), 10'(want.slot));
                    compare_field("old_height", 10'(m_old_height),
                                  10'($signed(want.old_h)));
                    compare_field("new_height", 10'(m_new_height),
                                  10'($signed(want.new_h)));
                    compare_field("top_out", 10'(m_top_out), 10'($signed(want.top)));
                    compare_field("redraw", 10'(m_redraw), 10'(want.redraw));
                    compare_field("map_from", 10'(m_map_from),
                                  10'($signed(want.map_from)));
                    compare_field("draw_low", 10'(m_draw_low),
                                  10'($signed(want.draw_low)));
                    compare_field("draw_high", 10'(m_draw_high),
                                  10'($signed(want.draw_high)));
                    if (m_redraw === 1'b1) redraw_total++;
                    checked_total++;
                end
            end
            if (s_valid && s_ready) begin
                predict_layer_op(func_t'(s_func), s_layer_id, s_target_height);
            end
        end
        failures        <= err_total;
        pending         <= expected_q.size();
        results_checked <= checked_total;
        repaints_seen   <= redraw_total;
    end

endmodule

>>> bench/layer_zorder_stack_tb.sv
// Testbench top for the layer z-order stack: clock, reset, stimulus, result stalls and verdict.
module layer_zorder_stack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzs_pkg::*;

    // Longest quiet stretch allowed: a full-depth shift plus stalls, taken many times over.
    localparam int WATCHDOG_LIMIT = 16 * LAYERS;
    localparam int SETTLE_CYCLES  = LAYERS + 44;

    localparam logic signed [REQ_W-1:0] HEIGHT_MIN  = -512;
    localparam logic signed [REQ_W-1:0] HEIGHT_MAX  = 511;
    localparam logic signed [REQ_W-1:0] HEIGHT_HIDE = -1;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [FUNC_W-1:0]         s_func;
    logic [SLOT_W-1:0]         s_layer_id;
    logic signed [REQ_W-1:0]   s_target_height;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_ok;
    logic [SLOT_W-1:0]         m_slot_out;
    logic signed [HGT_W-1:0]   m_old_height;
    logic signed [HGT_W-1:0]   m_new_height;
    logic signed [HGT_W-1:0]   m_top_out;
    logic                      m_redraw;
    logic signed [HGT_W-1:0]   m_map_from;
    logic signed [HGT_W-1:0]   m_draw_low;
    logic signed [HGT_W-1:0]   m_draw_high;

    int failures;
    int pending;
    int results_checked;
    int repaints_seen;

    // Stimulus bookkeeping: which slots the traffic believes are allocated.
    bit slot_live [0:LAYERS-1];
    int live_count;
    int op_count [4];
    int refused_allocs;
    bit idle_en;
    int stall_left;
    int quiet_cycles;

    layer_zorder_stack i_dut (.*);

    layer_zorder_stack_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stall bursts while idling is enabled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles in which no transaction moves on either channel.
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Present one transaction, optionally after an idle burst, and wait for its acceptance.
    task automatic issue_layer_op(input func_t op, input logic [SLOT_W-1:0] id,
                                  input logic signed [REQ_W-1:0] height);
        bit found;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= op;
        s_layer_id      <= id;
        s_target_height <= height;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        op_count[op]++;
        // Mirror slot allocation so that later traffic can aim at live slots.
        if (op == FUNC_ALLOC) begin
            found = 1'b0;
            for (int k = 0; k < LAYERS && !found; k++) begin
                if (!slot_live[k]) begin
                    slot_live[k] = 1'b1;
                    live_count++;
                    found = 1'b1;
                end
            end
            if (!found) refused_allocs++;
        end else if (op == FUNC_FREE && slot_live[id]) begin
            slot_live[id] = 1'b0;
            live_count--;
        end
    endtask

    function automatic logic [SLOT_W-1:0] pick_live_slot();
        int skip;
        if (live_count == 0) return 8'($urandom);
        skip = $urandom_range(0, live_count - 1);
        for (int k = 0; k < LAYERS; k++) begin
            if (slot_live[k]) begin
                if (skip == 0) return 8'(k);
                skip--;
            end
        end
        return 8'($urandom);
    endfunction

    // Mostly heights within the stack, sometimes a hide or a raw 10-bit value.
    function automatic logic signed [REQ_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return HEIGHT_HIDE;
        if (r == 1) return 10'($urandom);
        return 10'(int'($urandom_range(0, live_count + 1)) - 1);
    endfunction

    // Weighted traffic on live slots, with stray transactions mixed in that do not count.
    task automatic run_layer_traffic(input int items, input int w_alloc, input int w_move,
                                     input int w_free);
        int done;
        int roll;
        done = 0;
        while (done < items) begin
            if ($urandom_range(0, 99) < 8) begin
                issue_layer_op(func_t'($urandom_range(0, 3)), 8'($urandom), 10'($urandom));
            end else begin
                roll = $urandom_range(1, w_alloc + w_move + w_free);
                if (roll <= w_alloc) begin
                    issue_layer_op(FUNC_ALLOC, 8'($urandom), 10'($urandom));
                end else if (roll <= w_alloc + w_move) begin
                    issue_layer_op(FUNC_MOVE, pick_live_slot(), pick_height());
                end else begin
                    issue_layer_op(FUNC_FREE, pick_live_slot(), 10'($urandom));
                end
                done++;
            end
        end
    endtask

    // Hold the input channel idle until every predicted result has arrived.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_func          = FUNC_NOP;
        s_layer_id      = '0;
        s_target_height = '0;
        idle_en         = 1'b1;
        live_count      = 0;
        refused_allocs  = 0;
        for (int k = 0; k < 4; k++) op_count[k] = 0;
        for (int k = 0; k < LAYERS; k++) slot_live[k] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: unused slots, no-op, clamping, show, raise, lower, hide, free.
        issue_layer_op(FUNC_MOVE, 8'd0, 10'sd0);
        issue_layer_op(FUNC_FREE, 8'd255, HEIGHT_MIN);
        issue_layer_op(FUNC_NOP, 8'hAA, HEIGHT_MAX);
        repeat (3) issue_layer_op(FUNC_ALLOC, 8'd0, 10'sd0);
        // A hidden layer asking for the maximum lands just above the top.
        issue_layer_op(FUNC_MOVE, 8'd0, HEIGHT_MAX);
        issue_layer_op(FUNC_MOVE, 8'd1, 10'sd0);
        // A hidden layer sent below -1 stays hidden with nothing redrawn.
        issue_layer_op(FUNC_MOVE, 8'd2, HEIGHT_MIN);
        issue_layer_op(FUNC_MOVE, 8'd2, 10'sd2);
        // A shown layer cannot rise above the top, so this changes nothing.
        issue_layer_op(FUNC_MOVE, 8'd2, 10'sd300);
        issue_layer_op(FUNC_MOVE, 8'd2, 10'sd0);
        issue_layer_op(FUNC_MOVE, 8'd0, 10'sd1);
        issue_layer_op(FUNC_MOVE, 8'd1, HEIGHT_HIDE);
        issue_layer_op(FUNC_MOVE, 8'd0, 10'sd0);
        // Hiding the bottom layer leaves an empty repaint range.
        issue_layer_op(FUNC_MOVE, 8'd0, HEIGHT_HIDE);
        issue_layer_op(FUNC_MOVE, 8'd1, 10'sd0);
        issue_layer_op(FUNC_FREE, 8'd2, 10'sd0);
        issue_layer_op(FUNC_FREE, 8'd0, 10'sd0);
        issue_layer_op(FUNC_ALLOC, 8'd0, 10'sd0);
        issue_layer_op(FUNC_FREE, 8'd0, 10'sd0);
        issue_layer_op(FUNC_FREE, 8'd0, 10'sd0);
        issue_layer_op(FUNC_NOP, 8'hFF, HEIGHT_MIN);
        issue_layer_op(FUNC_MOVE, 8'hFF, 10'sd1);

        // Random part: build the stack up, fill the slot table and overflow it.
        run_layer_traffic(300, 40, 45, 10);
        while (live_count < LAYERS) issue_layer_op(FUNC_ALLOC, 8'($urandom), 10'($urandom));
        repeat (4) issue_layer_op(FUNC_ALLOC, 8'($urandom), 10'($urandom));
        run_layer_traffic(350, 8, 77, 15);

        // Let the block go idle before the next phase, which runs without idling.
        wait_for_results();
        idle_en <= 1'b0;
        run_layer_traffic(250, 30, 45, 25);
        idle_en <= 1'b1;
        run_layer_traffic(200, 30, 40, 30);
        run_layer_traffic(300, 5, 30, 65);
        idle_en <= 1'b0;
        run_layer_traffic(200, 35, 40, 25);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Summary: %0d in (%0d alloc, %0d move, %0d free, %0d no-op), %0d compared",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[FUNC_ALLOC], op_count[FUNC_MOVE], op_count[FUNC_FREE],
                 op_count[FUNC_NOP], results_checked);
        $display("Summary: %0d results asked for a repaint, %0d allocations hit a full table",
                 repaints_seen, refused_allocs);
        if (failures == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
